// File: rtl/rvfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rvfc_pkg;

    localparam int FRAC_BITS = 16;        // origin fraction bits
    localparam int DIR_FRAC = 14;         // direction fraction bits
    localparam int NUM_AXES = 3;          // 0 x, 1 y, 2 z
    localparam int NUM_W = 42;            // signed numerator width, enough for FRAC_BITS 24
    localparam int CELL_W = 33 - FRAC_BITS;
    localparam int SAT_SHIFT = 31 - DIR_FRAC;
    localparam int DIV_STEPS = 31;        // quotient bits below saturation
    localparam int Q_FIFO_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        FACE_DOWN  = 3'd0,
        FACE_UP    = 3'd1,
        FACE_NORTH = 3'd2,
        FACE_SOUTH = 3'd3,
        FACE_WEST  = 3'd4,
        FACE_EAST  = 3'd5
    } t_face;

    // One candidate face per axis; the sign of the direction picks which.
    typedef struct packed {
        logic        cand;   // face counts
        logic        far;    // upper plane of the axis
        logic        sat;    // quotient would exceed DIST_MAX
        logic [31:0] num;    // numerator, valid when not saturated
        logic [15:0] den;    // |direction|
    } t_axis_job;

    typedef struct packed {
        t_axis_job [NUM_AXES-1:0] ax;
        logic [NUM_AXES-1:0][15:0] cell_pos;
    } t_job;

    function automatic t_face face_of(input logic [1:0] axis, input logic far);
        t_face f;
        case (axis)
            2'd0:    f = far ? FACE_EAST : FACE_WEST;
            2'd1:    f = far ? FACE_UP : FACE_DOWN;
            2'd2:    f = far ? FACE_SOUTH : FACE_NORTH;
            default: f = FACE_DOWN;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ray_voxel_face_crossing_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Ray / unit voxel face crossing. Each input beat carries a ray (origin in signed
// Q16.16, direction in signed Q2.14) and an action in tuser: 0 finds the voxel
// holding the origin (snapping across a boundary within 0.001 the ray is heading
// for) and the face the ray leaves it through (distance > 0); 1 finds the face of
// the given voxel the ray enters first (distance >= 0). The result beat gives the
// face, the ray parameter (unsigned Q15.16, saturated to 2^31-1) and the voxel
// (0 for action 1), with a hit flag in tuser; on no hit face and distance are 0.
// One ray per clock is sustained while the output is ready; an accepted ray passes
// the queue, a load stage, the 31-stage bit-serial divider per axis and the output
// register. A 4-beat queue between the classifying front end and the divider
// pipeline lets the input keep flowing while the output is stalled, until it fills.
module ray_voxel_face_crossing_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, voxel_x, voxel_y, voxel_z
    input  wire logic [191:0] i_s_tdata,
    // action
    input  wire logic         i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // face, distance, cell_x, cell_y, cell_z, zero pad
    output logic [87:0]       o_m_tdata,
    // hit
    output logic              o_m_tuser
);
    import rvfc_pkg::*;

    logic [2:0][31:0] origin;
    logic [2:0][15:0] dir, voxel, cell_pos;
    t_job             f_job, q_job;
    logic             q_full, q_valid, pop, hit;
    logic [2:0]       face;
    logic [30:0]      dist_q;

    assign origin = i_s_tdata[95:0];
    assign dir    = i_s_tdata[143:96];
    assign voxel  = i_s_tdata[191:144];

    rvfc_front u_front (
        .i_enter  (i_s_tuser),
        .i_origin (origin),
        .i_dir    (dir),
        .i_voxel  (voxel),
        .o_job    (f_job)
    );

    assign o_s_tready = !q_full;

    rvfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    rvfc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_hit   (hit),
        .o_face  (face),
        .o_dist  (dist_q),
        .o_cell  (cell_pos)
    );

    assign o_m_tuser = hit;
    assign o_m_tdata = {6'd0, cell_pos, dist_q, face};

endmodule
`default_nettype wire

// File: rtl/rvfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rvfc_front (
    input  wire logic                     i_enter,
    input  wire logic [2:0][31:0]         i_origin,
    input  wire logic [2:0][15:0]         i_dir,
    input  wire logic [2:0][15:0]         i_voxel,
    output rvfc_pkg::t_job                o_job
);
    import rvfc_pkg::*;

    localparam logic signed [NUM_W-1:0] ONE = NUM_W'(1) << FRAC_BITS;

    always_comb begin
        logic [FRAC_BITS-1:0]        fr;
        logic [FRAC_BITS+9:0]        fr_k;
        logic                        dneg, dpos, lowf, highf;
        logic signed [CELL_W-1:0]    cell_idx;
        logic signed [NUM_W-1:0]     orel, o_abs, plane, num, lim;
        logic [16:0]                 vox;
        o_job = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            fr    = i_origin[a][FRAC_BITS-1:0];
            fr_k  = (FRAC_BITS+10)'(fr) * (FRAC_BITS+10)'(1000);
            dneg  = i_dir[a][15];
            dpos  = !i_dir[a][15] && (i_dir[a] != 16'd0);
            lowf  = fr_k < (FRAC_BITS+10)'(1) << FRAC_BITS;
            highf = fr_k > (FRAC_BITS+10)'(999) << FRAC_BITS;
            cell_idx = {i_origin[a][31], i_origin[a][31:FRAC_BITS]};
            orel  = NUM_W'(fr);
            // snap the cell across a boundary the ray is about to cross
            if (lowf && dneg) begin
                cell_idx = cell_idx - CELL_W'(1);
                orel = orel + ONE;
            end else if (highf && dpos) begin
                cell_idx = cell_idx + CELL_W'(1);
                orel = orel - ONE;
            end
            o_abs = {{(NUM_W-32){i_origin[a][31]}}, i_origin[a]};
            vox   = {i_voxel[a][15], i_voxel[a]} + 17'(dneg);
            plane = {{(NUM_W-17-FRAC_BITS){vox[16]}}, vox, {FRAC_BITS{1'b0}}};
            if (i_enter) begin
                num = dpos ? plane - o_abs : o_abs - plane;
            end else begin
                num = dpos ? ONE - orel : orel;
            end
            o_job.ax[a].den  = dneg ? 16'(-i_dir[a]) : i_dir[a];
            lim = NUM_W'(o_job.ax[a].den) << SAT_SHIFT;
            o_job.ax[a].cand = (i_dir[a] != 16'd0) &&
                               (i_enter ? !num[NUM_W-1] : (num > 0));
            o_job.ax[a].far  = i_enter ? dneg : dpos;
            o_job.ax[a].sat  = num >= lim;
            o_job.ax[a].num  = num[31:0];
            o_job.cell_pos[a] = i_enter ? 16'd0 : cell_idx[15:0];
        end
    end

endmodule
`default_nettype wire

// File: rtl/rvfc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rvfc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rvfc_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output rvfc_pkg::t_job      o_job
);
    import rvfc_pkg::*;

    t_job                 r_mem [Q_FIFO_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, r_rd;
    logic [Q_PTR_W:0]     r_cnt;
    logic                 do_push, do_pop;

    assign o_full  = r_cnt == (Q_PTR_W+1)'(Q_FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

endmodule
`default_nettype wire

// File: rtl/rvfc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rvfc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire rvfc_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_hit,
    output logic [2:0]          o_face,
    output logic [30:0]         o_dist,
    output logic [2:0][15:0]    o_cell
);
    import rvfc_pkg::*;

    // stage 0 holds the loaded job, stages 1..DIV_STEPS each retire one quotient bit
    logic                      r_v   [DIV_STEPS+1];
    t_job                      r_job [DIV_STEPS+1];
    logic [2:0][15:0]          r_rem [DIV_STEPS+1];
    logic [2:0][30:0]          r_low [DIV_STEPS+1];
    logic [2:0][30:0]          r_q   [DIV_STEPS+1];
    logic [2:0][15:0]          n_rem [DIV_STEPS+1];
    logic [2:0][30:0]          n_low [DIV_STEPS+1];
    logic [2:0][30:0]          n_q   [DIV_STEPS+1];
    logic                      en;
    logic                      n_hit;
    logic [2:0]                n_face;
    logic [30:0]               n_dist;

    assign en    = !o_valid || i_ready;
    assign o_pop = en;

    always_comb begin
        logic [16:0] t;
        logic        ge;
        for (int a = 0; a < NUM_AXES; a++) begin
            n_rem[0][a] = {1'b0, i_job.ax[a].num[31:SAT_SHIFT]};
            n_low[0][a] = {i_job.ax[a].num[SAT_SHIFT-1:0], {DIR_FRAC{1'b0}}};
            n_q[0][a]   = '0;
        end
        for (int s = 1; s <= DIV_STEPS; s++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                t  = {r_rem[s-1][a], r_low[s-1][a][30]};
                ge = t >= {1'b0, r_job[s-1].ax[a].den};
                n_rem[s][a] = ge ? 16'(t - {1'b0, r_job[s-1].ax[a].den}) : t[15:0];
                n_low[s][a] = {r_low[s-1][a][29:0], 1'b0};
                n_q[s][a]   = {r_q[s-1][a][29:0], ge};
            end
        end
    end

    // nearest face; y, z, x order keeps ties on the lowest face index
    always_comb begin
        logic [1:0]  ax;
        logic [30:0] d;
        n_hit  = 1'b0;
        n_face = '0;
        n_dist = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            ax = (i == 2) ? 2'd0 : 2'(i + 1);
            d  = r_job[DIV_STEPS].ax[ax].sat ? DIST_MAX : r_q[DIV_STEPS][ax];
            if (r_job[DIV_STEPS].ax[ax].cand && (!n_hit || d < n_dist)) begin
                n_hit  = 1'b1;
                n_dist = d;
                n_face = face_of(ax, r_job[DIV_STEPS].ax[ax].far);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STEPS; s++) r_v[s] <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= DIV_STEPS; s++) r_v[s] <= r_v[s-1];
            o_valid <= r_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_job[0] <= i_job;
            for (int s = 1; s <= DIV_STEPS; s++) r_job[s] <= r_job[s-1];
            for (int s = 0; s <= DIV_STEPS; s++) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_q[s]   <= n_q[s];
            end
            o_hit  <= n_hit;
            o_face <= n_face;
            o_dist <= n_dist;
            o_cell <= r_job[DIV_STEPS].cell_pos;
        end
    end

endmodule
`default_nettype wire
